// ----- rtl/dama_pkg.sv -----
package dama_pkg;

    localparam int READING_W = 32;
    localparam int WIN_W     = 5;
    localparam int OP_W      = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd5;

    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_MISSING = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/dama_in_if.sv -----
interface dama_in_if;

    logic                                 valid;
    logic                                 ready;
    logic [dama_pkg::OP_W-1:0]            op;
    logic signed [dama_pkg::READING_W-1:0] reading;

    modport source (output valid, output op, output reading, input ready);
    modport sink   (input valid, input op, input reading, output ready);

endinterface

// ----- rtl/dama_out_if.sv -----
interface dama_out_if #(
    parameter int CNT_W = 5
);

    logic                                  valid;
    logic                                  ready;
    logic                                  average_valid;
    logic signed [dama_pkg::READING_W-1:0] average;
    logic [CNT_W-1:0]                      held_count;

    modport source (output valid, output average_valid, output average, output held_count,
                    input ready);
    modport sink   (input valid, input average_valid, input average, input held_count,
                    output ready);

endinterface

// ----- rtl/dama_ring.sv -----
module dama_ring #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [IDX_W-1:0]                 waddr,
    input  logic [dama_pkg::READING_W-1:0]   wdata,
    input  logic [IDX_W-1:0]                 raddr,
    output logic [dama_pkg::READING_W-1:0]   rdata
);

    logic [dama_pkg::READING_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dama_serial_div.sv -----
module dama_serial_div #(
    parameter int SUM_W = 36,
    parameter int CNT_W = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [SUM_W-1:0]               dividend,
    input  logic [CNT_W-1:0]                      divisor,
    output dama_pkg::div_status_t                 status,
    output logic signed [dama_pkg::READING_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  divisor_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // one quotient bit per cycle, remainder stays as narrow as the count
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
            neg_reg     <= dividend[SUM_W-1];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = neg_reg ? -$signed(quo_reg[dama_pkg::READING_W-1:0])
                                 : $signed(quo_reg[dama_pkg::READING_W-1:0]);

endmodule

// ----- rtl/dropout_aware_moving_average_top.sv -----
// Sliding-window mean of signed Q16.16 readings over at most window_size recent
// readings (0 acts as 1, above WINDOW_MAX acts as WINDOW_MAX); a write of
// window_size empties the history. Each request yields one result. The mean
// of the SUM_W = 32 + log2(WINDOW_MAX) bit sum is formed by the bit-serial
// restoring divider that produces one quotient bit per cycle; when the window
// is empty the division is skipped. One item is in work at a time; the next
// request is taken while a finished result still waits in the output register.
// The history memory needs no clearing pass: only entries that hold readings
// are ever read.
module dropout_aware_moving_average_top #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dama_pkg::WIN_W-1:0]     cfg_wdata,
    dama_in_if.sink                        samples,
    dama_out_if.source                     results
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = dama_pkg::READING_W + $clog2(WINDOW_MAX);
    localparam int PTR_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > dama_pkg::WIN_W) ? CNT_W : dama_pkg::WIN_W;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_LOAD      = 6'b000010,
        ST_UPDATE    = 6'b000100,
        ST_DIV_START = 6'b001000,
        ST_DIVIDE    = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [dama_pkg::WIN_W-1:0]        window_size_reg, window_size_next;
    logic [IDX_W-1:0]                  oldest_reg, oldest_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic signed [SUM_W-1:0]           sum_reg, sum_next;
    logic [dama_pkg::OP_W-1:0]         op_reg;
    logic [dama_pkg::READING_W-1:0]    reading_reg;

    logic                              out_valid_reg, out_valid_next;
    logic                              out_avg_valid_reg;
    logic signed [dama_pkg::READING_W-1:0] out_average_reg;
    logic [CNT_W-1:0]                  out_count_reg;

    logic [CMP_W-1:0]                  win_ext;
    logic [CNT_W-1:0]                  win_eff;
    logic [PTR_W-1:0]                  slot_sum;
    logic [IDX_W-1:0]                  slot;
    logic [IDX_W-1:0]                  oldest_inc;
    logic [dama_pkg::READING_W-1:0]    rd_data;
    logic                              ring_we;
    logic                              accept;
    logic                              load_out;
    logic                              div_start;
    dama_pkg::div_status_t             div_st;
    logic signed [dama_pkg::READING_W-1:0] div_quotient;

    assign win_ext = CMP_W'(window_size_reg);

    always_comb
    begin
        priority if (window_size_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (win_ext > CMP_W'(WINDOW_MAX))
        begin
            win_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = CNT_W'(win_ext);
        end
    end

    // new slot sits count places past the oldest, whether or not one is dropped
    assign slot_sum   = PTR_W'(oldest_reg) + PTR_W'(count_reg);
    assign slot       = (slot_sum >= PTR_W'(WINDOW_MAX)) ?
                        IDX_W'(slot_sum - PTR_W'(WINDOW_MAX)) : IDX_W'(slot_sum);
    assign oldest_inc = (oldest_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : oldest_reg + 1'b1;

    assign accept   = samples.valid && samples.ready;
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        oldest_next      = oldest_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        ring_we          = 1'b0;
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                unique case (op_reg)
                    dama_pkg::OP_SAMPLE:
                    begin
                        ring_we = 1'b1;
                        if (count_reg >= win_eff)
                        begin
                            // drop oldest and append: count holds
                            oldest_next = oldest_inc;
                            sum_next    = sum_reg - SUM_W'($signed(rd_data))
                                          + SUM_W'($signed(reading_reg));
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            sum_next   = sum_reg + SUM_W'($signed(reading_reg));
                        end
                    end
                    dama_pkg::OP_MISSING:
                    begin
                        if (count_reg != '0)
                        begin
                            oldest_next = oldest_inc;
                            count_next  = count_reg - 1'b1;
                            sum_next    = sum_reg - SUM_W'($signed(rd_data));
                        end
                    end
                    dama_pkg::OP_CLEAR:
                    begin
                        oldest_next = '0;
                        count_next  = '0;
                        sum_next    = '0;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                if (count_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_st.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            window_size_next = cfg_wdata;
            oldest_next      = '0;
            count_next       = '0;
            sum_next         = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= dama_pkg::WINDOW_RESET;
            oldest_reg      <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            oldest_reg      <= oldest_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= samples.op;
            reading_reg <= samples.reading;
        end
        if (load_out)
        begin
            out_avg_valid_reg <= (count_reg != '0);
            out_average_reg   <= (count_reg != '0) ? div_quotient : '0;
            out_count_reg     <= count_reg;
        end
    end

    dama_ring #(
        .DEPTH (WINDOW_MAX),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot),
        .wdata (reading_reg),
        .raddr (oldest_reg),
        .rdata (rd_data)
    );

    dama_serial_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .status   (div_st),
        .quotient (div_quotient)
    );

    assign samples.ready         = (state_reg == ST_IDLE);
    assign results.valid         = out_valid_reg;
    assign results.average_valid = out_avg_valid_reg;
    assign results.average       = out_average_reg;
    assign results.held_count    = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= win_eff)
    else $error("held count exceeds the effective window");

    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.average_valid |->
            results.average == '0 && results.held_count == '0)
    else $error("invalid mean carries a nonzero value or count");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == ST_DIVIDE)
    else $error("divider finished outside the divide state");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_st.busy)
    else $error("divider did not start");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam logic [dama_pkg::OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [dama_pkg::READING_W-1:0] READ_MAX     = 32'h7FFF_FFFF;
    localparam logic [dama_pkg::READING_W-1:0] READ_MIN     = 32'h8000_0000;
    localparam int                             HIST_DEPTH   = 16;
    localparam int                             N_PHASES     = 10;
    localparam int                             PHASE_ITEMS  = 143;
    localparam int                             DRAIN_CYCLES = 60;
    localparam int                             DUE_DEPTH    = 16;
    localparam int                             ROW_CAP      = 40;

    typedef struct {
        logic                                  average_valid;
        logic signed [dama_pkg::READING_W-1:0] average;
        logic [dama_pkg::WIN_W-1:0]            held_count;
    } average_t;

    typedef enum {ROW_ITEM, ROW_WINDOW} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [dama_pkg::OP_W-1:0]        op;
        logic [dama_pkg::READING_W-1:0]   reading;
        logic [dama_pkg::WIN_W-1:0]       window;
        bit                               literal;
        average_t                         want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [dama_pkg::WIN_W-1:0] cfg_wdata;

    dama_in_if                               samples_if ();
    dama_out_if #(.CNT_W(dama_pkg::WIN_W))   results_if ();

    dropout_aware_moving_average_top #(
        .WINDOW_MAX (HIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_if.sink),
        .results   (results_if.source)
    );

    // Window model state
    logic signed [dama_pkg::READING_W-1:0] hist_ring [HIST_DEPTH];
    logic [3:0]                            hist_oldest;
    logic [dama_pkg::WIN_W-1:0]            hist_count;
    longint                                hist_sum;
    logic [dama_pkg::WIN_W-1:0]            window_reg;

    // Expected results, oldest at due_head
    average_t averages_due [DUE_DEPTH];
    int       due_head;
    int       due_tail;

    stim_row_t rows [ROW_CAP];
    int        n_rows;

    bit src_idle_on;
    bit sink_idle_on;
    int errors;
    int n_requests;
    int n_checked;
    int n_windows;
    int n_displaced;
    int n_empty;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void clear_history();
        hist_oldest = '0;
        hist_count  = '0;
        hist_sum    = 0;
    endfunction

    function automatic void drop_oldest_reading();
        if (hist_count != 0)
        begin
            hist_sum    = hist_sum - hist_ring[hist_oldest];
            hist_oldest = hist_oldest + 4'd1;
            hist_count  = hist_count - 5'd1;
        end
    endfunction

    function automatic average_t next_average(input logic [dama_pkg::OP_W-1:0] op,
                                              input logic signed [dama_pkg::READING_W-1:0] reading);
        logic [dama_pkg::WIN_W-1:0] win;
        logic [3:0]                 slot;
        longint                     mean;
        average_t                   res;
        if (window_reg == 0)
            win = 5'd1;
        else if (window_reg > HIST_DEPTH)
            win = 5'd16;
        else
            win = window_reg;
        case (op)
            dama_pkg::OP_SAMPLE:
            begin
                while (hist_count >= win)
                begin
                    drop_oldest_reading();
                    n_displaced++;
                end
                slot            = hist_oldest + hist_count[3:0];
                hist_ring[slot] = reading;
                hist_sum        = hist_sum + reading;
                hist_count      = hist_count + 5'd1;
            end
            dama_pkg::OP_MISSING: drop_oldest_reading();
            dama_pkg::OP_CLEAR:   clear_history();
            default:    ;
        endcase
        if (hist_count != 0)
        begin
            mean              = hist_sum / longint'(hist_count);
            res.average_valid = 1'b1;
            res.average       = mean[dama_pkg::READING_W-1:0];
        end
        else
        begin
            res.average_valid = 1'b0;
            res.average       = '0;
            n_empty++;
        end
        res.held_count = hist_count;
        return res;
    endfunction

    function automatic stim_row_t item_row(input logic [dama_pkg::OP_W-1:0] op,
                                           input logic [dama_pkg::READING_W-1:0] reading,
                                           input bit literal, input logic avg_valid,
                                           input logic [dama_pkg::READING_W-1:0] avg,
                                           input logic [dama_pkg::WIN_W-1:0] cnt);
        stim_row_t row;
        row.kind               = ROW_ITEM;
        row.op                 = op;
        row.reading            = reading;
        row.window             = '0;
        row.literal            = literal;
        row.want.average_valid = avg_valid;
        row.want.average       = avg;
        row.want.held_count    = cnt;
        return row;
    endfunction

    function automatic stim_row_t window_row(input logic [dama_pkg::WIN_W-1:0] value);
        stim_row_t row;
        row        = item_row(dama_pkg::OP_CLEAR, '0, 1'b0, 1'b0, '0, '0);
        row.kind   = ROW_WINDOW;
        row.window = value;
        return row;
    endfunction

    function automatic void add_row(input stim_row_t row);
        rows[n_rows] = row;
        n_rows++;
    endfunction

    function automatic logic [dama_pkg::READING_W-1:0] random_reading();
        case ($urandom_range(0, 9))
            0:       return READ_MAX;
            1:       return READ_MIN;
            2:       return 32'(int'($urandom_range(0, 393216)) - 196608);
            3:       return '0;
            4:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [dama_pkg::OP_W-1:0] random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 83)
            return dama_pkg::OP_SAMPLE;
        else if (r < 96)
            return dama_pkg::OP_MISSING;
        else if (r < 98)
            return dama_pkg::OP_CLEAR;
        else
            return OP_UNUSED;
    endfunction

    function automatic logic [dama_pkg::WIN_W-1:0] phase_window(input int p);
        case (p)
            0:       return 5'd1;
            1:       return 5'd16;
            2:       return 5'd0;
            3:       return 5'd31;
            4:       return 5'd17;
            5:       return 5'd3;
            6:       return 5'($urandom_range(2, 15));
            7:       return 5'($urandom_range(18, 30));
            8:       return dama_pkg::WINDOW_RESET;
            default: return 5'd16;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH result %0d: %s got %0d expected %0d", n_checked, what, got, want);
        errors++;
    endtask

    task automatic send_request(input logic [dama_pkg::OP_W-1:0] op,
                                input logic [dama_pkg::READING_W-1:0] reading,
                                input bit literal, input average_t want);
        average_t predicted;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            samples_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        samples_if.valid   <= 1'b1;
        samples_if.op      <= op;
        samples_if.reading <= reading;
        do
            @(posedge clk);
        while (samples_if.ready !== 1'b1);
        predicted = next_average(op, reading);
        averages_due[due_tail % DUE_DEPTH] = literal ? want : predicted;
        due_tail++;
        n_requests++;
    endtask

    task automatic drain_averages();
        samples_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_tail != due_head);
    endtask

    task automatic write_window(input logic [dama_pkg::WIN_W-1:0] value);
        drain_averages();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        window_reg = value;
        clear_history();
        n_windows++;
    endtask

    // Result sink with bursty back-pressure
    initial
    begin
        results_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                results_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        average_t exp_avg;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1)
            begin
                if (due_tail == due_head)
                    report_mismatch("result with nothing pending, average", results_if.average, 0);
                else
                begin
                    exp_avg = averages_due[due_head % DUE_DEPTH];
                    due_head++;
                    if (results_if.average_valid !== exp_avg.average_valid)
                        report_mismatch("average_valid", results_if.average_valid,
                                        exp_avg.average_valid);
                    if (results_if.average !== exp_avg.average)
                        report_mismatch("average", results_if.average, exp_avg.average);
                    if (results_if.held_count !== exp_avg.held_count)
                        report_mismatch("held_count", results_if.held_count,
                                        exp_avg.held_count);
                end
                n_checked++;
            end
        end
    end

    initial
    begin
        average_t  none;
        int        p;
        int        k;
        int        r;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        samples_if.valid   <= 1'b0;
        samples_if.op      <= dama_pkg::OP_SAMPLE;
        samples_if.reading <= '0;
        none.average_valid = 1'b0;
        none.average       = '0;
        none.held_count    = '0;
        window_reg         = dama_pkg::WINDOW_RESET;
        clear_history();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        // Empty history, then saturate the reset window with extremes
        add_row(item_row(dama_pkg::OP_MISSING, '0,            1'b1, 1'b0, '0, 5'd0));
        add_row(item_row(dama_pkg::OP_CLEAR,   '0,            1'b1, 1'b0, '0, 5'd0));
        add_row(item_row(OP_UNUSED,            32'h5A5A_5A5A, 1'b1, 1'b0, '0, 5'd0));
        for (k = 1; k <= 6; k++)
            add_row(item_row(dama_pkg::OP_SAMPLE, READ_MAX, 1'b1, 1'b1, READ_MAX,
                             (k > 5) ? 5'd5 : 5'(k)));
        add_row(item_row(dama_pkg::OP_CLEAR,   '0,            1'b1, 1'b0, '0, 5'd0));
        add_row(item_row(dama_pkg::OP_SAMPLE,  READ_MIN,      1'b1, 1'b1, READ_MIN, 5'd1));
        add_row(item_row(dama_pkg::OP_SAMPLE,  READ_MIN,      1'b1, 1'b1, READ_MIN, 5'd2));
        add_row(item_row(dama_pkg::OP_SAMPLE,  READ_MAX,      1'b0, 1'b0, '0, '0));
        add_row(item_row(dama_pkg::OP_SAMPLE,  32'd1,         1'b0, 1'b0, '0, '0));
        add_row(item_row(dama_pkg::OP_SAMPLE,  -32'sd3,       1'b0, 1'b0, '0, '0));
        add_row(item_row(OP_UNUSED,            32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0));
        for (k = 0; k < 5; k++)
            add_row(item_row(dama_pkg::OP_MISSING, '0, 1'b0, 1'b0, '0, '0));
        add_row(item_row(dama_pkg::OP_MISSING, '0,            1'b1, 1'b0, '0, 5'd0));
        // Window of zero behaves as one
        add_row(window_row(5'd0));
        add_row(item_row(dama_pkg::OP_SAMPLE,  32'h0001_8000, 1'b1, 1'b1, 32'h0001_8000, 5'd1));
        add_row(item_row(dama_pkg::OP_SAMPLE,  -32'sd7,       1'b1, 1'b1, -32'sd7, 5'd1));
        // Oversized window, and a mean that truncates toward zero
        add_row(window_row(5'd31));
        add_row(item_row(dama_pkg::OP_SAMPLE,  -32'sd1,       1'b0, 1'b0, '0, '0));
        add_row(item_row(dama_pkg::OP_SAMPLE,  32'd2,         1'b0, 1'b0, '0, '0));
        add_row(item_row(dama_pkg::OP_SAMPLE,  -32'sd4,       1'b0, 1'b0, '0, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < n_rows; r++)
        begin
            if (rows[r].kind == ROW_WINDOW)
                write_window(rows[r].window);
            else
                send_request(rows[r].op, rows[r].reading, rows[r].literal, rows[r].want);
        end

        for (p = 0; p < N_PHASES; p++)
        begin
            src_idle_on  = (p != N_PHASES - 1) && (p % 3 != 1);
            sink_idle_on = (p != N_PHASES - 1) && (p % 4 != 2);
            write_window(phase_window(p));
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Hold off until the pipeline is empty once mid-run
                if (p == 4 && k == PHASE_ITEMS / 2)
                    drain_averages();
                send_request(random_op(), random_reading(), 1'b0, none);
            end
        end

        drain_averages();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d window settings (0, 1, 16, 17, 31 among them)",
                 n_requests + 0, n_windows);
        $display("Checked %0d averages: %0d with the oldest reading displaced, %0d empty",
                 n_checked, n_displaced, n_empty);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dama_pkg.sv
rtl/dama_in_if.sv
rtl/dama_out_if.sv
rtl/dama_ring.sv
rtl/dama_serial_div.sv
rtl/dropout_aware_moving_average_top.sv
dv/tb.sv
